>>> rtl/bfa_pkg.sv
// Shared types, constants and arithmetic helpers for the flocking agent update.
package bfa_pkg;

  // Neighbour limit and derived widths
  localparam int MAX_NEIGHBOURS = 1024;
  localparam int CNT_W          = $clog2(MAX_NEIGHBOURS + 1);
  localparam int DIV_W          = 47;
  localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
  localparam int SQ_W           = 64;
  localparam int SQ_STEPS       = SQ_W / 2;

  // Record kinds
  localparam logic OP_OWN = 1'b0;
  localparam logic OP_NBR = 1'b1;

  // Register reset values
  localparam logic [15:0] SEP_GAIN_RST = 16'd655;
  localparam logic [15:0] ALI_GAIN_RST = 16'd655;
  localparam logic [15:0] COH_GAIN_RST = 16'd66;
  localparam logic [11:0] VIEW_RST     = 12'd100;
  localparam logic [11:0] WIN_W_RST    = 12'd800;
  localparam logic [11:0] WIN_H_RST    = 12'd600;

  typedef enum logic [2:0] {
    CFG_SEP_GAIN = 3'd0,
    CFG_ALI_GAIN = 3'd1,
    CFG_COH_GAIN = 3'd2,
    CFG_VIEW     = 3'd3,
    CFG_WIN_W    = 3'd4,
    CFG_WIN_H    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] sep_gain;
    logic [15:0] ali_gain;
    logic [15:0] coh_gain;
    logic [11:0] view;
    logic [11:0] win_w;
    logic [11:0] win_h;
  } cfg_t;

  typedef struct packed {
    logic        is_own;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] speed;
    logic        last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RANGE, S_DIST, S_SQRT, S_DIVX, S_DIVY, S_SEP, S_ALI,
    S_COH, S_CDIVX, S_CDIVY, S_CLO, S_CHI, S_CADD, S_MAG, S_MSUM, S_MSQRT,
    S_NDIVX, S_NDIVY, S_STEP, S_WRAP
  } st_t;

  // Clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -44'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Clamp to signed 42 bits
  function automatic logic signed [41:0] sat42(input logic signed [43:0] v);
    if (v > 44'sd2199023255551) begin
      sat42 = {1'b0, {41{1'b1}}};
    end else if (v < -44'sd2199023255552) begin
      sat42 = {1'b1, {41{1'b0}}};
    end else begin
      sat42 = v[41:0];
    end
  endfunction

  // Divide a gain product by 2^16, truncating toward zero
  function automatic logic signed [43:0] q16_trunc(input logic signed [32:0] p);
    logic [32:0] m;
    m = p[32] ? 33'(-p) : 33'(p);
    q16_trunc = p[32] ? -$signed(44'(m[32:16])) : $signed(44'(m[32:16]));
  endfunction

  // Divide a speed product by 2^6, truncating toward zero
  function automatic logic signed [33:0] q6_trunc(input logic signed [31:0] p);
    logic [31:0] m;
    m = p[31] ? 32'(-p) : 32'(p);
    q6_trunc = p[31] ? -$signed(34'(m[31:6])) : $signed(34'(m[31:6]));
  endfunction

  // Wrap once at the window edge, then clamp
  function automatic logic signed [31:0] wrap_pos(input logic signed [33:0] p,
                                                  input logic [11:0] size);
    logic signed [35:0] w;
    logic signed [35:0] v;
    w = $signed({8'b0, size, 16'b0});
    v = 36'(p);
    if (v <= 0) begin
      v = v + w;
    end else if (v >= w) begin
      v = v - w;
    end
    wrap_pos = sat32(44'(v));
  endfunction

endpackage

>>> rtl/bfa_if.sv
// Channel interfaces: agent records in, updated agents out, register writes.
interface bfa_item_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] speed;
  logic               last;
  modport source(output valid, opcode, pos_x, pos_y, dir_x, dir_y, speed, last,
                 input ready);
  modport sink(input valid, opcode, pos_x, pos_y, dir_x, dir_y, speed, last,
               output ready);
endinterface

interface bfa_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [15:0] new_dir_x;
  logic signed [15:0] new_dir_y;
  modport source(output valid, new_pos_x, new_pos_y, new_dir_x, new_dir_y,
                 input ready);
  modport sink(input valid, new_pos_x, new_pos_y, new_dir_x, new_dir_y,
               output ready);
endinterface

interface bfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/bfa_front.sv
// Front end: accepts records, tags their kind and queues them for the engine.
module bfa_front (
  input  logic           clk,
  input  logic           rst,
  bfa_item_if.sink       items,
  output bfa_pkg::head_t head,
  input  logic           pop
);
  import bfa_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign items.ready = (count != 2'd2);
  assign push        = items.valid && items.ready;
  assign head.valid  = (count != 2'd0);
  assign head.item   = mem[rd_ptr];

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{is_own: (items.opcode == OP_OWN),
                       pos_x: items.pos_x, pos_y: items.pos_y,
                       dir_x: items.dir_x, dir_y: items.dir_y,
                       speed: items.speed, last: items.last};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> rtl/bfa_isqrt.sv
// Integer square root, two radicand bits per cycle.
module bfa_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bfa_pkg::SQ_W-1:0]  n,
  output logic [bfa_pkg::SQ_W/2-1:0] root,
  output logic                      done
);
  import bfa_pkg::*;

  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] r;
  logic [SQ_W-1:0] b;
  logic [SQ_W-1:0] trial;
  logic            busy;

  assign trial = r + b;
  assign root  = r[SQ_W/2-1:0];

  // Hold data path
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= n;
      r   <= '0;
      b   <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        r   <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

  // Run until the last bit pair
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && b[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/bfa_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module bfa_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bfa_pkg::DIV_W-1:0] num,
  input  logic [31:0]               den_in,
  output logic [bfa_pkg::DIV_W-1:0] quo,
  output logic                      done
);
  import bfa_pkg::*;

  logic [DIV_W-1:0]     q;
  logic [31:0]          rem;
  logic [31:0]          den;
  logic [DIV_CNT_W-1:0] left;
  logic                 busy;
  logic [32:0]          shifted;
  logic [32:0]          diff;
  logic                 ge;

  assign shifted = {rem, q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};
  assign quo     = q;

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      den <= den_in;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : shifted[31:0];
      q   <= {q[DIV_W-2:0], ge};
    end
  end

  // Count quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/bfa_back.sv
// Back end: per-record steering arithmetic and the final direction and position step.
module bfa_back (
  input  logic           clk,
  input  logic           rst,
  input  bfa_pkg::cfg_t  cfg,
  input  bfa_pkg::head_t head,
  output logic           pop,
  bfa_result_if.source   results
);
  import bfa_pkg::*;

  st_t state;
  st_t state_next;
  st_t fin_next;

  item_t it;

  // Agent state
  logic signed [31:0] own_px, own_py;
  logic signed [15:0] own_spd;
  logic signed [31:0] acc_x, acc_y;
  logic signed [41:0] csum_x, csum_y;
  logic [CNT_W-1:0]   ncnt;

  // Per-record working registers
  logic signed [32:0] dx, dy;
  logic [32:0]        ax_m, ay_m;
  logic [55:0]        sqx, sqy, lim2;
  logic [31:0]        len;
  logic signed [15:0] ux, uy;

  // Final-step working registers
  logic signed [31:0] fin_x, fin_y;
  logic [42:0]        exm_x, exm_y;
  logic               exn_x, exn_y;
  logic [37:0]        plo_x, plo_y;
  logic [58:0]        pm_x, pm_y;
  logic [63:0]        mx2, my2;
  logic signed [15:0] nx, ny;
  logic signed [33:0] npx, npy;

  // Result register
  logic               out_valid;
  logic signed [31:0] out_px, out_py;
  logic signed [15:0] out_dx, out_dy;

  // Shared units
  logic              sq_start, sq_done;
  logic [SQ_W-1:0]   sq_n;
  logic [SQ_W/2-1:0] sq_root;
  logic              dv_start, dv_done;
  logic [DIV_W-1:0]  dv_num, dv_q;
  logic [31:0]       dv_den;

  // Combinational arithmetic
  logic [27:0]        lim;
  logic [56:0]        d2;
  logic [63:0]        m2;
  logic signed [32:0] dx_c, dy_c;
  logic signed [32:0] sp_x, sp_y, al_x, al_y;
  logic               cd_neg;
  logic signed [43:0] cq_s, ex_c;
  logic [36:0]        phi_x, phi_y;
  logic signed [43:0] ct_x, ct_y;
  logic [31:0]        finm_x, finm_y;
  logic signed [31:0] st_x, st_y;
  logic               out_free;

  assign lim      = {cfg.view, 16'b0};
  assign d2       = {1'b0, sqx} + {1'b0, sqy};
  assign m2       = mx2 + my2;
  assign dx_c     = 33'(own_px) - 33'($signed(it.pos_x));
  assign dy_c     = 33'(own_py) - 33'($signed(it.pos_y));
  assign sp_x     = $signed({1'b0, cfg.sep_gain}) * ux;
  assign sp_y     = $signed({1'b0, cfg.sep_gain}) * uy;
  assign al_x     = $signed({1'b0, cfg.ali_gain}) * $signed(it.dir_x);
  assign al_y     = $signed({1'b0, cfg.ali_gain}) * $signed(it.dir_y);
  assign cd_neg   = (state == S_CDIVX) ? csum_x[41] : csum_y[41];
  assign cq_s     = cd_neg ? -$signed({1'b0, dv_q[42:0]}) : $signed({1'b0, dv_q[42:0]});
  assign ex_c     = cq_s - ((state == S_CDIVX) ? 44'(own_px) : 44'(own_py));
  assign phi_x    = exm_x[42:22] * cfg.coh_gain;
  assign phi_y    = exm_y[42:22] * cfg.coh_gain;
  assign ct_x     = exn_x ? -$signed(44'(pm_x[58:18])) : $signed(44'(pm_x[58:18]));
  assign ct_y     = exn_y ? -$signed(44'(pm_y[58:18])) : $signed(44'(pm_y[58:18]));
  assign finm_x   = fin_x[31] ? 32'(-fin_x) : 32'(fin_x);
  assign finm_y   = fin_y[31] ? 32'(-fin_y) : 32'(fin_y);
  assign st_x     = own_spd * nx;
  assign st_y     = own_spd * ny;
  assign out_free = !out_valid || results.ready;
  assign fin_next = it.last ? S_COH : S_IDLE;

  assign results.valid     = out_valid;
  assign results.new_pos_x = out_px;
  assign results.new_pos_y = out_py;
  assign results.new_dir_x = out_dx;
  assign results.new_dir_y = out_dy;

  bfa_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .n    (sq_n),
    .root (sq_root),
    .done (sq_done)
  );

  bfa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den_in(dv_den),
    .quo   (dv_q),
    .done  (dv_done)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit starts
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    sq_start   = 1'b0;
    sq_n       = '0;
    dv_start   = 1'b0;
    dv_num     = '0;
    dv_den     = '0;
    case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!it.is_own && ncnt < CNT_W'(MAX_NEIGHBOURS)) begin
          state_next = S_RANGE;
        end else begin
          state_next = fin_next;
        end
      end
      S_RANGE: begin
        if (ax_m < {5'b0, lim} && ay_m < {5'b0, lim}) begin
          state_next = S_DIST;
        end else begin
          state_next = fin_next;
        end
      end
      S_DIST: begin
        if (d2 < {1'b0, lim2}) begin
          if (d2 != '0) begin
            sq_start   = 1'b1;
            sq_n       = 64'(d2);
            state_next = S_SQRT;
          end else begin
            state_next = S_ALI;
          end
        end else begin
          state_next = fin_next;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          dv_start   = 1'b1;
          dv_num     = DIV_W'({ax_m[27:0], 14'b0});
          dv_den     = sq_root;
          state_next = S_DIVX;
        end
      end
      S_DIVX: begin
        if (dv_done) begin
          dv_start   = 1'b1;
          dv_num     = DIV_W'({ay_m[27:0], 14'b0});
          dv_den     = len;
          state_next = S_DIVY;
        end
      end
      S_DIVY: begin
        if (dv_done) begin
          state_next = S_SEP;
        end
      end
      S_SEP: state_next = S_ALI;
      S_ALI: state_next = fin_next;
      S_COH: begin
        if (ncnt == '0) begin
          state_next = S_MAG;
        end else begin
          dv_start   = 1'b1;
          dv_num     = DIV_W'(csum_x[41] ? 42'(-csum_x) : 42'(csum_x));
          dv_den     = 32'(ncnt);
          state_next = S_CDIVX;
        end
      end
      S_CDIVX: begin
        if (dv_done) begin
          dv_start   = 1'b1;
          dv_num     = DIV_W'(csum_y[41] ? 42'(-csum_y) : 42'(csum_y));
          dv_den     = 32'(ncnt);
          state_next = S_CDIVY;
        end
      end
      S_CDIVY: begin
        if (dv_done) begin
          state_next = S_CLO;
        end
      end
      S_CLO:  state_next = S_CHI;
      S_CHI:  state_next = S_CADD;
      S_CADD: state_next = S_MAG;
      S_MAG:  state_next = S_MSUM;
      S_MSUM: begin
        if (m2 != '0) begin
          sq_start   = 1'b1;
          sq_n       = m2;
          state_next = S_MSQRT;
        end else begin
          state_next = S_STEP;
        end
      end
      S_MSQRT: begin
        if (sq_done) begin
          dv_start   = 1'b1;
          dv_num     = DIV_W'({finm_x, 14'b0});
          dv_den     = sq_root;
          state_next = S_NDIVX;
        end
      end
      S_NDIVX: begin
        if (dv_done) begin
          dv_start   = 1'b1;
          dv_num     = DIV_W'({finm_y, 14'b0});
          dv_den     = len;
          state_next = S_NDIVY;
        end
      end
      S_NDIVY: begin
        if (dv_done) begin
          state_next = S_STEP;
        end
      end
      S_STEP: state_next = S_WRAP;
      S_WRAP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Agent state: load on own record, accumulate on counted neighbours
  always_ff @(posedge clk) begin
    if (rst) begin
      own_px  <= '0;
      own_py  <= '0;
      own_spd <= '0;
      acc_x   <= '0;
      acc_y   <= '0;
      csum_x  <= '0;
      csum_y  <= '0;
      ncnt    <= '0;
    end else begin
      case (state)
        S_DECODE: begin
          if (it.is_own) begin
            own_px  <= it.pos_x;
            own_py  <= it.pos_y;
            own_spd <= it.speed;
            acc_x   <= 32'($signed(it.dir_x));
            acc_y   <= 32'($signed(it.dir_y));
            csum_x  <= '0;
            csum_y  <= '0;
            ncnt    <= '0;
          end
        end
        S_SEP: begin
          acc_x <= sat32(44'(acc_x) + q16_trunc(sp_x));
          acc_y <= sat32(44'(acc_y) + q16_trunc(sp_y));
        end
        S_ALI: begin
          acc_x  <= sat32(44'(acc_x) + q16_trunc(al_x));
          acc_y  <= sat32(44'(acc_y) + q16_trunc(al_y));
          csum_x <= sat42(44'(csum_x) + 44'($signed(it.pos_x)));
          csum_y <= sat42(44'(csum_y) + 44'($signed(it.pos_y)));
          ncnt   <= ncnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop) begin
          it <= head.item;
        end
      end
      S_DECODE: begin
        dx   <= dx_c;
        dy   <= dy_c;
        ax_m <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
        ay_m <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
      end
      S_RANGE: begin
        sqx  <= ax_m[27:0] * ax_m[27:0];
        sqy  <= ay_m[27:0] * ay_m[27:0];
        lim2 <= lim * lim;
      end
      S_SQRT: begin
        if (sq_done) begin
          len <= sq_root;
        end
      end
      S_DIVX: begin
        if (dv_done) begin
          ux <= dx[32] ? -$signed(dv_q[15:0]) : $signed(dv_q[15:0]);
        end
      end
      S_DIVY: begin
        if (dv_done) begin
          uy <= dy[32] ? -$signed(dv_q[15:0]) : $signed(dv_q[15:0]);
        end
      end
      S_COH: begin
        fin_x <= acc_x;
        fin_y <= acc_y;
      end
      S_CDIVX: begin
        if (dv_done) begin
          exm_x <= ex_c[43] ? 43'(-ex_c) : ex_c[42:0];
          exn_x <= ex_c[43];
        end
      end
      S_CDIVY: begin
        if (dv_done) begin
          exm_y <= ex_c[43] ? 43'(-ex_c) : ex_c[42:0];
          exn_y <= ex_c[43];
        end
      end
      S_CLO: begin
        plo_x <= exm_x[21:0] * cfg.coh_gain;
        plo_y <= exm_y[21:0] * cfg.coh_gain;
      end
      S_CHI: begin
        pm_x <= {phi_x, 22'b0} + 59'(plo_x);
        pm_y <= {phi_y, 22'b0} + 59'(plo_y);
      end
      S_CADD: begin
        fin_x <= sat32(44'(fin_x) + ct_x);
        fin_y <= sat32(44'(fin_y) + ct_y);
      end
      S_MAG: begin
        mx2 <= finm_x * finm_x;
        my2 <= finm_y * finm_y;
      end
      S_MSUM: begin
        if (m2 == '0) begin
          nx <= '0;
          ny <= '0;
        end
      end
      S_MSQRT: begin
        if (sq_done) begin
          len <= sq_root;
        end
      end
      S_NDIVX: begin
        if (dv_done) begin
          nx <= fin_x[31] ? -$signed(dv_q[15:0]) : $signed(dv_q[15:0]);
        end
      end
      S_NDIVY: begin
        if (dv_done) begin
          ny <= fin_y[31] ? -$signed(dv_q[15:0]) : $signed(dv_q[15:0]);
        end
      end
      S_STEP: begin
        npx <= 34'(own_px) + q6_trunc(st_x);
        npy <= 34'(own_py) + q6_trunc(st_y);
      end
      S_WRAP: begin
        if (out_free) begin
          out_px <= wrap_pos(npx, cfg.win_w);
          out_py <= wrap_pos(npy, cfg.win_h);
          out_dx <= nx;
          out_dy <= ny;
        end
      end
      default: ;
    endcase
  end

  // Result word valid: set on wrap, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_WRAP && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/boids_flock_agent_update_top.sv
// Top level of the flocking agent update: registers, record queue and engine.
// An own-agent word starts an update; neighbour words follow, the one with last
// set closes it and yields one updated position and direction. Words enter a
// two-deep queue and are worked one at a time by a sequencer that shares one
// square-root unit and one divider. An in-range neighbour at a nonzero distance
// runs the root and two divides; a closing word runs the cohesion divides when
// neighbours were counted, then, for a nonzero sum, the root and two divides,
// and may wait for the result register to empty. The result register lets the
// next update start while the last result waits. Registers are written at any
// time through the configuration channel, which is always ready; write them
// only while no update is in flight.
module boids_flock_agent_update_top (
  input logic          clk,
  input logic          rst,
  bfa_item_if.sink     items,
  bfa_result_if.source results,
  bfa_cfg_if.sink      cfg
);
  import bfa_pkg::*;

  cfg_t  cfg_regs;
  head_t head;
  logic  pop;

  assign cfg.ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '{sep_gain: SEP_GAIN_RST, ali_gain: ALI_GAIN_RST,
                    coh_gain: COH_GAIN_RST, view: VIEW_RST,
                    win_w: WIN_W_RST, win_h: WIN_H_RST};
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SEP_GAIN: cfg_regs.sep_gain <= cfg.data;
        CFG_ALI_GAIN: cfg_regs.ali_gain <= cfg.data;
        CFG_COH_GAIN: cfg_regs.coh_gain <= cfg.data;
        CFG_VIEW:     cfg_regs.view     <= cfg.data[11:0];
        CFG_WIN_W:    cfg_regs.win_w    <= cfg.data[11:0];
        CFG_WIN_H:    cfg_regs.win_h    <= cfg.data[11:0];
        default: ;
      endcase
    end
  end

  bfa_front u_front (
    .clk  (clk),
    .rst  (rst),
    .items(items),
    .head (head),
    .pop  (pop)
  );

  bfa_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .head   (head),
    .pop    (pop),
    .results(results)
  );

`ifndef SYNTHESIS
  // Engine takes a word only from a filled queue
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");

  // Engine decodes each word before taking another
  assert property (@(posedge clk) disable iff (rst) pop |=> !pop)
    else $error("back-to-back pops");

  // Reset restores the default weights
  assert property (@(posedge clk) $past(rst) |->
                   (cfg_regs.sep_gain == SEP_GAIN_RST && cfg_regs.coh_gain == COH_GAIN_RST))
    else $error("register defaults lost after reset");
`endif

endmodule

>>> sim/tb_boids_flock_agent_update_top.sv
// Testbench for the flocking agent update: directed table, then random agent updates.
`timescale 1ns / 1ps

module tb_boids_flock_agent_update_top;
  import bfa_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int DRAIN_CYCLES    = 600;

  typedef struct {
    logic               opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] speed;
    logic               last;
  } rec_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } upd_t;

  // Directed row: record plus optional typed-in expectation
  typedef struct {
    rec_t rec;
    bit   has_exp;
    upd_t exp;
  } row_t;

  logic clk;
  logic rst;

  bfa_item_if   items();
  bfa_result_if results();
  bfa_cfg_if    cfg();

  boids_flock_agent_update_top dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

  // Predictor copy of registers and state
  longint m_sep, m_ali, m_coh, m_view, m_w, m_h;
  longint m_own_x, m_own_y, m_speed, m_acc_x, m_acc_y, m_sum_x, m_sum_y;
  longint m_count;

  upd_t   expected_updates[$];
  upd_t   typed_updates[$];
  bit     typed_valid[$];
  int     errors;
  int     words_sent;
  int     updates_seen;
  int     idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clamp32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint wrap_edge(longint p, longint size);
    longint w;
    w = size << 16;
    if (p <= 0) p += w;
    else if (p >= w) p -= w;
    return clamp32(p);
  endfunction

  function automatic void load_reg(cfg_idx_t idx, longint v);
    case (idx)
      CFG_SEP_GAIN: m_sep  = v & 16'hFFFF;
      CFG_ALI_GAIN: m_ali  = v & 16'hFFFF;
      CFG_COH_GAIN: m_coh  = v & 16'hFFFF;
      CFG_VIEW:     m_view = v & 12'hFFF;
      CFG_WIN_W:    m_w    = v & 12'hFFF;
      CFG_WIN_H:    m_h    = v & 12'hFFF;
      default: ;
    endcase
  endfunction

  // Advance the agent state by one record; return 1 with the update on last
  function automatic bit steer_agent(rec_t r, output upd_t u);
    longint px, py, dx, dy, lim, ax, ay, d2, len, ux, uy, ex, ey, nx, ny;
    longint unsigned m2;
    px = r.pos_x;
    py = r.pos_y;
    if (r.opcode == OP_OWN) begin
      m_own_x = px;
      m_own_y = py;
      m_speed = r.speed;
      m_acc_x = r.dir_x;
      m_acc_y = r.dir_y;
      m_sum_x = 0;
      m_sum_y = 0;
      m_count = 0;
    end else if (m_count < MAX_NEIGHBOURS) begin
      dx = m_own_x - px;
      dy = m_own_y - py;
      lim = m_view << 16;
      ax = abs64(dx);
      ay = abs64(dy);
      if (ax < lim && ay < lim && ax * ax + ay * ay < lim * lim) begin
        d2 = ax * ax + ay * ay;
        if (d2 != 0) begin
          len = int_sqrt(d2);
          ux = (dx * 16384) / len;
          uy = (dy * 16384) / len;
          m_acc_x = clamp32(m_acc_x + (m_sep * ux) / 65536);
          m_acc_y = clamp32(m_acc_y + (m_sep * uy) / 65536);
        end
        m_acc_x = clamp32(m_acc_x + (m_ali * longint'(r.dir_x)) / 65536);
        m_acc_y = clamp32(m_acc_y + (m_ali * longint'(r.dir_y)) / 65536);
        m_sum_x = clamp(m_sum_x + px, -(64'sd1 << 41), (64'sd1 << 41) - 1);
        m_sum_y = clamp(m_sum_y + py, -(64'sd1 << 41), (64'sd1 << 41) - 1);
        m_count++;
      end
    end
    if (!r.last) return 0;
    ax = m_acc_x;
    ay = m_acc_y;
    nx = 0;
    ny = 0;
    if (m_count > 0) begin
      ex = m_sum_x / m_count - m_own_x;
      ey = m_sum_y / m_count - m_own_y;
      ax = clamp32(ax + (m_coh * ex) / 262144);
      ay = clamp32(ay + (m_coh * ey) / 262144);
    end
    m2 = abs64(ax) * abs64(ax) + abs64(ay) * abs64(ay);
    if (m2 != 0) begin
      len = int_sqrt(m2);
      nx = (ax * 16384) / len;
      ny = (ay * 16384) / len;
    end
    u.pos_x = 32'(wrap_edge(m_own_x + (m_speed * nx) / 64, m_w));
    u.pos_y = 32'(wrap_edge(m_own_y + (m_speed * ny) / 64, m_h));
    u.dir_x = 16'(nx);
    u.dir_y = 16'(ny);
    return 1;
  endfunction

  // Drive one word with bursty gaps and log its expectation
  task automatic send_word(rec_t r, bit has_typed, upd_t typed);
    upd_t u;
    if ($urandom_range(0, 3) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    items.valid  <= 1'b1;
    items.opcode <= r.opcode;
    items.pos_x  <= r.pos_x;
    items.pos_y  <= r.pos_y;
    items.dir_x  <= r.dir_x;
    items.dir_y  <= r.dir_y;
    items.speed  <= r.speed;
    items.last   <= r.last;
    do @(posedge clk); while (!items.ready);
    if (steer_agent(r, u)) begin
      expected_updates.push_back(u);
      typed_updates.push_back(typed);
      typed_valid.push_back(has_typed);
    end
    words_sent++;
  endtask

  task automatic idle_items();
    items.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_updates();
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hold valid across a group of writes; the caller drops it afterwards
  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    load_reg(idx, v);
  endtask

  function automatic rec_t mk(logic op, int px, int py, int dx, int dy, int sp,
                              logic lst);
    rec_t r;
    r.opcode = op;
    r.pos_x  = px;
    r.pos_y  = py;
    r.dir_x  = 16'(dx);
    r.dir_y  = 16'(dy);
    r.speed  = 16'(sp);
    r.last   = lst;
    return r;
  endfunction

  function automatic rec_t rand_rec(logic op, logic lst, int cx, int cy, int spread);
    rec_t r;
    r.opcode = op;
    if (spread == 0) begin
      r.pos_x = $urandom;
      r.pos_y = $urandom;
    end else begin
      r.pos_x = cx + $signed($urandom_range(0, 2 * spread)) - spread;
      r.pos_y = cy + $signed($urandom_range(0, 2 * spread)) - spread;
    end
    r.dir_x = $urandom;
    r.dir_y = $urandom;
    r.speed = $urandom;
    r.last  = lst;
    return r;
  endfunction

  // Receiver stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      results.ready <= ($urandom_range(0, 9) < 6) || (updates_seen % 7 == 3);
    end
  end

  // Compare each accepted update with the oldest expectation
  always @(posedge clk) begin
    upd_t e, t;
    bit   tv;
    if (!rst && results.valid && results.ready) begin
      updates_seen++;
      if (expected_updates.size() == 0) begin
        $display("%0t: unexpected update %h %h %h %h", $time, results.new_pos_x,
                 results.new_pos_y, results.new_dir_x, results.new_dir_y);
        errors++;
      end else begin
        e = expected_updates.pop_front();
        t = typed_updates.pop_front();
        tv = typed_valid.pop_front();
        if (tv && (t.pos_x !== e.pos_x || t.pos_y !== e.pos_y ||
                   t.dir_x !== e.dir_x || t.dir_y !== e.dir_y)) begin
          $display("%0t: table row disagrees with predictor: table %h %h %h %h pred %h %h %h %h",
                   $time, t.pos_x, t.pos_y, t.dir_x, t.dir_y,
                   e.pos_x, e.pos_y, e.dir_x, e.dir_y);
          errors++;
        end
        if (results.new_pos_x !== e.pos_x) begin
          $display("%0t: new_pos_x expected %h actual %h", $time, e.pos_x,
                   results.new_pos_x);
          errors++;
        end
        if (results.new_pos_y !== e.pos_y) begin
          $display("%0t: new_pos_y expected %h actual %h", $time, e.pos_y,
                   results.new_pos_y);
          errors++;
        end
        if (results.new_dir_x !== e.dir_x) begin
          $display("%0t: new_dir_x expected %h actual %h", $time, e.dir_x,
                   results.new_dir_x);
          errors++;
        end
        if (results.new_dir_y !== e.dir_y) begin
          $display("%0t: new_dir_y expected %h actual %h", $time, e.dir_y,
                   results.new_dir_y);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready)
        || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d updates outstanding", $time,
               expected_updates.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    row_t  dir_rows[$];
    upd_t  none;
    rec_t  r;
    int    agent_n, nbr_n, cx, cy, spread, phase;

    errors = 0;
    words_sent = 0;
    updates_seen = 0;
    idle_cycles = 0;
    none = '{0, 0, 0, 0};
    items.valid = 1'b0;
    items.opcode = OP_OWN;
    items.pos_x = '0;
    items.pos_y = '0;
    items.dir_x = '0;
    items.dir_y = '0;
    items.speed = '0;
    items.last = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_SEP_GAIN;
    cfg.data = '0;
    m_sep = SEP_GAIN_RST; m_ali = ALI_GAIN_RST; m_coh = COH_GAIN_RST;
    m_view = VIEW_RST; m_w = WIN_W_RST; m_h = WIN_H_RST;
    m_own_x = 0; m_own_y = 0; m_speed = 0; m_acc_x = 0; m_acc_y = 0;
    m_sum_x = 0; m_sum_y = 0; m_count = 0;

    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; expectations typed in where obvious
    // neighbour straight after reset, closing: zero state stays put at origin wrap
    dir_rows.push_back('{mk(OP_NBR, 32'sh7FFFFFFF, 0, 0, 0, 0, 1), 1,
                         '{32'sh03200000, 32'sh02580000, 0, 0}});
    // own record closing alone: zero direction, origin wraps to window size
    dir_rows.push_back('{mk(OP_OWN, 0, 0, 0, 0, 32767, 1), 1,
                         '{32'sh03200000, 32'sh02580000, 0, 0}});
    // unit direction along x, zero speed
    dir_rows.push_back('{mk(OP_OWN, 32'h00100000, 32'h00100000, 16384, 0, 0, 1), 1,
                         '{32'h00100000, 32'h00100000, 16384, 0}});
    // extremes of direction and speed
    dir_rows.push_back('{mk(OP_OWN, 32'sh80000000, 32'sh7FFFFFFF, -32768, 32767,
                            -32768, 1), 0, none});
    dir_rows.push_back('{mk(OP_OWN, 32'sh7FFFFFFF, 32'sh80000000, 32767, -32768,
                            32767, 1), 0, none});
    // coincident neighbour, near neighbour, out-of-range neighbour
    dir_rows.push_back('{mk(OP_OWN, 32'h01000000, 32'h01000000, 0, 0, 256, 0), 0, none});
    dir_rows.push_back('{mk(OP_NBR, 32'h01000000, 32'h01000000, 16384, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk(OP_NBR, 32'h01050000, 32'h00FD0000, -16384, 16384, 0, 0),
                         0, none});
    dir_rows.push_back('{mk(OP_NBR, 32'h02000000, 32'h01000000, 16384, 16384, 0, 1),
                         0, none});
    // neighbours after a result keep accumulating
    dir_rows.push_back('{mk(OP_NBR, 32'h00FF8000, 32'h01004000, 32767, -32768, -1, 0),
                         0, none});
    dir_rows.push_back('{mk(OP_NBR, 32'h01000001, 32'h01000000, 0, 0, 0, 1), 0, none});
    // exactly at view distance is excluded
    dir_rows.push_back('{mk(OP_OWN, 32'h00000000, 32'h00000000, 100, 0, 512, 0), 0, none});
    dir_rows.push_back('{mk(OP_NBR, 32'h00640000, 32'h00000000, 0, 16384, 0, 0), 0, none});
    dir_rows.push_back('{mk(OP_NBR, 32'h00000000, 32'sh00000000 - 32'h00640000, 0, 0, 0,
                            1), 0, none});
    foreach (dir_rows[i]) send_word(dir_rows[i].rec, dir_rows[i].has_exp,
                                    dir_rows[i].exp);
    idle_items();

    // Random phases under several register settings, extremes included
    for (phase = 0; phase < 6; phase++) begin
      drain_updates();
      case (phase)
        0: begin
          write_reg(CFG_SEP_GAIN, 16'hFFFF); write_reg(CFG_ALI_GAIN, 16'hFFFF);
          write_reg(CFG_COH_GAIN, 16'hFFFF); write_reg(CFG_VIEW, 16'd4095);
          write_reg(CFG_WIN_W, 16'd4095); write_reg(CFG_WIN_H, 16'd4095);
        end
        1: begin
          write_reg(CFG_SEP_GAIN, 16'd0); write_reg(CFG_ALI_GAIN, 16'd0);
          write_reg(CFG_COH_GAIN, 16'd0); write_reg(CFG_VIEW, 16'd0);
          write_reg(CFG_WIN_W, 16'd1); write_reg(CFG_WIN_H, 16'd1);
        end
        2: begin
          // zero window: no wrap
          write_reg(CFG_WIN_W, 16'd0); write_reg(CFG_WIN_H, 16'd0);
          write_reg(CFG_VIEW, 16'd200);
        end
        default: begin
          write_reg(CFG_SEP_GAIN, 16'($urandom)); write_reg(CFG_ALI_GAIN, 16'($urandom));
          write_reg(CFG_COH_GAIN, 16'($urandom));
          write_reg(CFG_VIEW, 16'($urandom_range(1, 4095)));
          write_reg(CFG_WIN_W, 16'($urandom_range(1, 4095)));
          write_reg(CFG_WIN_H, 16'($urandom_range(1, 4095)));
        end
      endcase
      cfg.valid <= 1'b0;
      for (agent_n = 0; agent_n < 18; agent_n++) begin
        cx = $urandom;
        if ($urandom_range(0, 1)) cx = $signed($urandom_range(0, 32'h0FFFFFFF));
        cy = $urandom;
        if ($urandom_range(0, 1)) cy = $signed($urandom_range(0, 32'h0FFFFFFF));
        spread = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 32'h00C00000);
        nbr_n = $urandom_range(0, 8);
        r = rand_rec(OP_OWN, nbr_n == 0, 0, 0, 0);
        r.pos_x = cx;
        r.pos_y = cy;
        send_word(r, 0, none);
        for (int k = 1; k <= nbr_n; k++) begin
          r = rand_rec(OP_NBR, k == nbr_n, cx, cy, spread);
          if ($urandom_range(0, 15) == 0) begin
            r.pos_x = cx;
            r.pos_y = cy;
          end
          // occasional broken sequence: early last
          if ($urandom_range(0, 19) == 0) r.last = 1'b1;
          send_word(r, 0, none);
        end
      end
      idle_items();
    end

    drain_updates();
    $display("Sent %0d agent words over six register settings, checked %0d updates.",
             words_sent, updates_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
